@@ sv/crhc_pkg.sv @@
// Shared types and constants of the cluster height classifier.
// Used by the top module, crhc_front and crhc_back; depends on nothing else.
package crhc_pkg;

    // Default sizing of the block.
    localparam int MAX_BOXES_DEF  = 4;
    localparam int COORD_BITS_DEF = 24;

    // Fixed field widths.
    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 2;
    localparam int COUNT_W = 3;
    localparam int INDEX_W = 16;

    // Depth of the queues between the front, the back and the result side.
    localparam int QUEUE_DEPTH = 4;

    // Configuration port.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Input commands.
    typedef enum logic [CMD_W-1:0] {
        CMD_POINT      = 2'd0,
        CMD_LOAD_HANG  = 2'd1,
        CMD_LOAD_FLOAT = 2'd2,
        CMD_RESTART    = 2'd3
    } cmd_t;

    // Register indexes of the configuration port.
    typedef enum logic [1:0] {
        REG_HANG_HEIGHT     = 2'd0,
        REG_FLOAT_HEIGHT    = 2'd1,
        REG_HANG_BOX_COUNT  = 2'd2,
        REG_FLOAT_BOX_COUNT = 2'd3
    } reg_idx_t;

    // One classified item handed from the front to the back.
    typedef struct packed {
        logic restart;    // restart the frame
        logic hang_hit;   // point lies in some hang box
        logic float_hit;  // point lies in some float box
        logic high;       // z at or above the hang height
        logic low;        // z at or below the float height
        logic last;       // last point of its cluster
    } work_t;

    // One result of a finished cluster.
    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic               selected;
    } result_t;

endpackage

@@ sv/cluster_roi_height_classifier.sv @@
// Cluster height classifier. One item (point, box load or frame restart) is
// taken per clock cycle at full rate while the work queue has room; the box
// compares of all boxes run in parallel in the front end. A cluster's result
// reaches the result side through a four-entry work queue and a four-entry
// result queue, so either side may stall on its own.
// Registers: hang_height at 0x0, float_height at 0x4, hang_box_count at 0x8,
// float_box_count at 0xC. Boxes are loaded with input items.
// Depends on crhc_pkg, crhc_fifo, crhc_front and crhc_back.
module cluster_roi_height_classifier #(
    parameter int MAX_BOXES  = crhc_pkg::MAX_BOXES_DEF,
    parameter int COORD_BITS = crhc_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [crhc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [crhc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [crhc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    // Input items
    input  logic                                push,
    output logic                                full,
    input  logic [crhc_pkg::CMD_W-1:0]          command,
    input  logic signed [COORD_BITS-1:0]        coord_x,
    input  logic signed [COORD_BITS-1:0]        coord_y,
    input  logic signed [COORD_BITS-1:0]        coord_z,
    input  logic signed [COORD_BITS-1:0]        box_max_x,
    input  logic signed [COORD_BITS-1:0]        box_max_y,
    input  logic signed [COORD_BITS-1:0]        box_max_z,
    input  logic [crhc_pkg::SLOT_W-1:0]         box_slot,
    input  logic                                cluster_end,
    // Results
    output logic                                empty,
    input  logic                                pop,
    output logic [crhc_pkg::INDEX_W-1:0]        cluster_index,
    output logic                                selected
);

    localparam int WORK_W   = $bits(crhc_pkg::work_t);
    localparam int RESULT_W = $bits(crhc_pkg::result_t);

    logic signed [COORD_BITS-1:0]      hang_height_reg;
    logic signed [COORD_BITS-1:0]      float_height_reg;
    logic [crhc_pkg::COUNT_W-1:0]      hang_count_reg;
    logic [crhc_pkg::COUNT_W-1:0]      float_count_reg;
    logic                              cfg_write;
    crhc_pkg::reg_idx_t                reg_idx;

    logic                              accept;
    logic                              work_push;
    crhc_pkg::work_t                   work_in;
    crhc_pkg::work_t                   work_out;
    logic [WORK_W-1:0]                 work_out_bits;
    logic                              work_pop;
    logic                              work_empty;
    logic                              result_push;
    logic                              result_full;
    crhc_pkg::result_t                 result_in;
    logic [RESULT_W-1:0]               result_out_bits;
    crhc_pkg::result_t                 result_out;

    // Configuration registers; a write completes in the access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = crhc_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hang_height_reg  <= '0;
            float_height_reg <= '0;
            hang_count_reg   <= '0;
            float_count_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                crhc_pkg::REG_HANG_HEIGHT:     hang_height_reg  <= pwdata[COORD_BITS-1:0];
                crhc_pkg::REG_FLOAT_HEIGHT:    float_height_reg <= pwdata[COORD_BITS-1:0];
                crhc_pkg::REG_HANG_BOX_COUNT:  hang_count_reg   <= pwdata[2:0];
                crhc_pkg::REG_FLOAT_BOX_COUNT: float_count_reg  <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (reg_idx)
            crhc_pkg::REG_HANG_HEIGHT:
                prdata = crhc_pkg::APB_DATA_W'(unsigned'(hang_height_reg));
            crhc_pkg::REG_FLOAT_HEIGHT:
                prdata = crhc_pkg::APB_DATA_W'(unsigned'(float_height_reg));
            crhc_pkg::REG_HANG_BOX_COUNT:
                prdata = crhc_pkg::APB_DATA_W'(hang_count_reg);
            crhc_pkg::REG_FLOAT_BOX_COUNT:
                prdata = crhc_pkg::APB_DATA_W'(float_count_reg);
            default:
                prdata = '0;
        endcase
    end

    // An input transfer completes whenever the work queue has room.
    assign accept = push && !full;

    crhc_front #(
        .MAX_BOXES  (MAX_BOXES),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk             (clk),
        .accept          (accept),
        .command         (command),
        .coord_x         (coord_x),
        .coord_y         (coord_y),
        .coord_z         (coord_z),
        .box_max_x       (box_max_x),
        .box_max_y       (box_max_y),
        .box_max_z       (box_max_z),
        .box_slot        (box_slot),
        .cluster_end     (cluster_end),
        .hang_height     (hang_height_reg),
        .float_height    (float_height_reg),
        .hang_box_count  (hang_count_reg),
        .float_box_count (float_count_reg),
        .work_push       (work_push),
        .work            (work_in)
    );

    // Work queue between front and back.
    crhc_fifo #(
        .WIDTH (WORK_W),
        .DEPTH (crhc_pkg::QUEUE_DEPTH)
    ) u_work_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (work_push),
        .push_data (work_in),
        .full      (full),
        .pop       (work_pop),
        .pop_data  (work_out_bits),
        .empty     (work_empty)
    );

    assign work_out = crhc_pkg::work_t'(work_out_bits);

    crhc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .work_empty  (work_empty),
        .work        (work_out),
        .work_pop    (work_pop),
        .result_full (result_full),
        .result_push (result_push),
        .result      (result_in)
    );

    // Result queue toward the consumer.
    crhc_fifo #(
        .WIDTH (RESULT_W),
        .DEPTH (crhc_pkg::QUEUE_DEPTH)
    ) u_result_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (result_push),
        .push_data (result_in),
        .full      (result_full),
        .pop       (pop),
        .pop_data  (result_out_bits),
        .empty     (empty)
    );

    assign result_out    = crhc_pkg::result_t'(result_out_bits);
    assign cluster_index = result_out.index;
    assign selected      = result_out.selected;

endmodule

@@ sv/crhc_fifo.sv @@
// Small first-in first-out queue of flip-flops used between the stages.
// Depends on nothing but its parameters.
module crhc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ sv/crhc_front.sv @@
// Front end: holds the box tables, loads boxes and classifies each point.
// Depends on crhc_pkg for the command codes and the work item type.
module crhc_front #(
    parameter int MAX_BOXES  = crhc_pkg::MAX_BOXES_DEF,
    parameter int COORD_BITS = crhc_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                accept,
    input  logic [crhc_pkg::CMD_W-1:0]          command,
    input  logic signed [COORD_BITS-1:0]        coord_x,
    input  logic signed [COORD_BITS-1:0]        coord_y,
    input  logic signed [COORD_BITS-1:0]        coord_z,
    input  logic signed [COORD_BITS-1:0]        box_max_x,
    input  logic signed [COORD_BITS-1:0]        box_max_y,
    input  logic signed [COORD_BITS-1:0]        box_max_z,
    input  logic [crhc_pkg::SLOT_W-1:0]         box_slot,
    input  logic                                cluster_end,
    input  logic signed [COORD_BITS-1:0]        hang_height,
    input  logic signed [COORD_BITS-1:0]        float_height,
    input  logic [crhc_pkg::COUNT_W-1:0]        hang_box_count,
    input  logic [crhc_pkg::COUNT_W-1:0]        float_box_count,
    output logic                                work_push,
    output crhc_pkg::work_t                     work
);

    // Box tables: one minimum and one maximum per axis and box.
    logic signed [COORD_BITS-1:0] hang_min  [MAX_BOXES][3];
    logic signed [COORD_BITS-1:0] hang_max  [MAX_BOXES][3];
    logic signed [COORD_BITS-1:0] float_min [MAX_BOXES][3];
    logic signed [COORD_BITS-1:0] float_max [MAX_BOXES][3];

    logic [MAX_BOXES-1:0] hang_in;
    logic [MAX_BOXES-1:0] float_in;
    logic                 is_point;
    logic                 is_restart;

    // Box loads write one slot; a slot beyond the table is dropped.
    for (genvar b = 0; b < MAX_BOXES; b++)
    begin : g_box
        always_ff @(posedge clk)
        begin
            if (accept && (32'(box_slot) == b))
            begin
                if (command == crhc_pkg::CMD_LOAD_HANG)
                begin
                    hang_min[b][0] <= coord_x;
                    hang_min[b][1] <= coord_y;
                    hang_min[b][2] <= coord_z;
                    hang_max[b][0] <= box_max_x;
                    hang_max[b][1] <= box_max_y;
                    hang_max[b][2] <= box_max_z;
                end
                if (command == crhc_pkg::CMD_LOAD_FLOAT)
                begin
                    float_min[b][0] <= coord_x;
                    float_min[b][1] <= coord_y;
                    float_min[b][2] <= coord_z;
                    float_max[b][0] <= box_max_x;
                    float_max[b][1] <= box_max_y;
                    float_max[b][2] <= box_max_z;
                end
            end
        end

        // All boxes are tested in parallel; only boxes below the count take part.
        assign hang_in[b] = (32'(hang_box_count) > b)
            && (hang_min[b][0] <= coord_x) && (coord_x <= hang_max[b][0])
            && (hang_min[b][1] <= coord_y) && (coord_y <= hang_max[b][1])
            && (hang_min[b][2] <= coord_z) && (coord_z <= hang_max[b][2]);
        assign float_in[b] = (32'(float_box_count) > b)
            && (float_min[b][0] <= coord_x) && (coord_x <= float_max[b][0])
            && (float_min[b][1] <= coord_y) && (coord_y <= float_max[b][1])
            && (float_min[b][2] <= coord_z) && (coord_z <= float_max[b][2]);
    end

    // Points and frame restarts go on to the back end; box loads stop here.
    assign is_point   = (command == crhc_pkg::CMD_POINT);
    assign is_restart = (command == crhc_pkg::CMD_RESTART);
    assign work_push  = accept && (is_point || is_restart);

    always_comb
    begin
        work.restart   = is_restart;
        work.hang_hit  = |hang_in;
        work.float_hit = |float_in;
        work.high      = (hang_height <= coord_z);
        work.low       = (float_height >= coord_z);
        work.last      = cluster_end;
    end

endmodule

@@ sv/crhc_back.sv @@
// Back end: accumulates the cluster flags, counts clusters, forms results.
// Depends on crhc_pkg for the work item and result types.
module crhc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              work_empty,
    input  crhc_pkg::work_t   work,
    output logic              work_pop,
    input  logic              result_full,
    output logic              result_push,
    output crhc_pkg::result_t result
);

    logic                         in_hang_reg, in_hang_next;
    logic                         in_float_reg, in_float_next;
    logic                         hanging_reg, hanging_next;
    logic                         floating_reg, floating_next;
    logic [crhc_pkg::INDEX_W-1:0] counter_reg, counter_next;
    logic                         acc_hang;
    logic                         acc_float;
    logic                         acc_high;
    logic                         acc_floating;
    logic                         ends_cluster;

    // A work item that ends a cluster waits for room in the result queue.
    assign ends_cluster = !work.restart && work.last;
    assign work_pop     = !work_empty && (!ends_cluster || !result_full);
    assign result_push  = work_pop && ends_cluster;

    // Flags including the point now being taken.
    assign acc_hang     = in_hang_reg || work.hang_hit;
    assign acc_float    = in_float_reg || work.float_hit;
    assign acc_high     = hanging_reg || work.high;
    assign acc_floating = floating_reg && !work.low;

    always_comb
    begin
        result.index    = counter_reg;
        result.selected = (acc_hang && acc_high) || (acc_float && acc_floating);
    end

    // Flag and counter update for each transfer from the work queue.
    always_comb
    begin
        in_hang_next  = in_hang_reg;
        in_float_next = in_float_reg;
        hanging_next  = hanging_reg;
        floating_next = floating_reg;
        counter_next  = counter_reg;
        if (work_pop)
        begin
            if (work.restart || work.last)
            begin
                in_hang_next  = 1'b0;
                in_float_next = 1'b0;
                hanging_next  = 1'b0;
                floating_next = 1'b1;
            end
            else
            begin
                in_hang_next  = acc_hang;
                in_float_next = acc_float;
                hanging_next  = acc_high;
                floating_next = acc_floating;
            end
            if (work.restart)
            begin
                counter_next = '0;
            end
            else if (work.last)
            begin
                counter_next = counter_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_hang_reg  <= 1'b0;
            in_float_reg <= 1'b0;
            hanging_reg  <= 1'b0;
            floating_reg <= 1'b1;
            counter_reg  <= '0;
        end
        else
        begin
            in_hang_reg  <= in_hang_next;
            in_float_reg <= in_float_next;
            hanging_reg  <= hanging_next;
            floating_reg <= floating_next;
            counter_reg  <= counter_next;
        end
    end

endmodule
